// ===== rtl/max_pool_3x3_stride2_macros.svh =====
// assertion macros shared by the max pool rtl
`ifndef MAX_POOL_3X3_STRIDE2_MACROS_SVH
`define MAX_POOL_3X3_STRIDE2_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define MP_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("max pool check failed");

// next-cycle implication, clocked on i_clk, off while in reset
`define MP_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("max pool check failed");

`endif

// ===== rtl/mp_pkg.sv =====
// shared types, constants and helpers for the max pool block
package mp_pkg;

    localparam int unsigned MAX_WIDTH    = 16;
    localparam int unsigned WINDOW       = 3;
    localparam int unsigned STEP         = 2;
    localparam int unsigned DATA_BITS    = 16;
    localparam int unsigned OUT_BITS     = DATA_BITS - 1;
    localparam int unsigned LINES        = WINDOW - 1;
    localparam int unsigned COL_BITS     = $clog2(MAX_WIDTH);
    localparam int unsigned WIDTH_BITS   = 5;
    localparam int unsigned CHAN_BITS    = 11;
    localparam int unsigned MAX_CHANNELS = 1024;
    localparam int unsigned CHPOS_BITS   = $clog2(MAX_CHANNELS);

    localparam logic [WIDTH_BITS-1:0] MAP_WIDTH_RST  = 5'd13;
    localparam logic [CHAN_BITS-1:0]  CHAN_COUNT_RST = 11'd384;

    typedef logic signed [DATA_BITS-1:0] t_pixel;
    typedef logic [OUT_BITS-1:0]         t_value;
    typedef logic [COL_BITS-1:0]         t_col;
    typedef t_pixel                      t_column [WINDOW];

    typedef enum logic [0:0] {
        CFG_MAP_WIDTH     = 1'b0,
        CFG_CHANNEL_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic emit;
        logic map_end;
        logic frame_end;
        t_col col;
    } t_pos_info;

    // maximum of one window column and zero
    function automatic t_value col_max(input t_column col);
        t_pixel best;
        best = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if ($signed(col[i]) > $signed(best)) begin
                best = col[i];
            end
        end
        return best[OUT_BITS-1:0];
    endfunction

endpackage

// ===== rtl/mp_if.sv =====
// stream interfaces for the pixel input and the pooled output
interface mp_pixel_if;
    import mp_pkg::*;
    logic   valid;
    logic   ready;
    t_pixel pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface mp_pool_if;
    import mp_pkg::*;
    logic   valid;
    logic   ready;
    t_value pooled_value;
    logic   map_end;
    logic   frame_end;
    modport source (output valid, output pooled_value, output map_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pooled_value, input map_end, input frame_end,
                    output ready);
endinterface

// ===== rtl/mp_cell.sv =====
// one window column cell: holds a column maximum and extends the running max
module mp_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  mp_pkg::t_value i_val,
    input  mp_pkg::t_value i_max,
    output mp_pkg::t_value o_val,
    output mp_pkg::t_value o_max
);
    import mp_pkg::*;

    t_value r_val;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_val;
        end
    end

    assign o_val = r_val;
    assign o_max = (r_val > i_max) ? r_val : i_max;

endmodule

// ===== rtl/mp_line_store.sv =====
// line stores for the rows above the current one, read and rotated per column
module mp_line_store (
    input  logic            i_clk,
    input  logic            i_we,
    input  mp_pkg::t_col    i_col,
    input  mp_pkg::t_pixel  i_pixel,
    output mp_pkg::t_column o_column
);
    import mp_pkg::*;

    // line 0 is the oldest row
    t_pixel r_line [LINES][MAX_WIDTH];

    always_comb begin
        for (int i = 0; i < LINES; i++) begin
            o_column[i] = r_line[i][i_col];
        end
        o_column[WINDOW-1] = i_pixel;
    end

    // each line moves up one row at this column
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int i = 0; i < LINES; i++) begin
                r_line[i][i_col] <= o_column[i+1];
            end
        end
    end

endmodule

// ===== rtl/mp_ctrl.sv =====
// configuration registers, position counters and emit / end flag decode
module mp_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  mp_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [mp_pkg::CHAN_BITS-1:0]   i_cfg_data,
    input  logic                           i_adv,
    output mp_pkg::t_pos_info              o_pos
);
    import mp_pkg::*;

    logic [WIDTH_BITS-1:0] r_map_width;
    logic [CHAN_BITS-1:0]  r_chan_count;
    t_col                  r_col;
    t_col                  r_row;
    logic [CHPOS_BITS-1:0] r_chan;

    logic [WIDTH_BITS-1:0] w_eff;
    logic [WIDTH_BITS-1:0] w_m1;
    logic [WIDTH_BITS-1:0] w_rem;
    logic [WIDTH_BITS-1:0] last_pos;
    logic [CHPOS_BITS-1:0] chans_m1;
    logic                  row_last;
    logic                  map_last;
    logic                  chan_last;
    logic                  mend;

    function automatic logic on_grid(input t_col pos);
        return (pos >= COL_BITS'(WINDOW - 1)) &&
               (((pos - COL_BITS'(WINDOW - 1)) % STEP) == 0);
    endfunction

    always_comb begin
        if (r_map_width < WIDTH_BITS'(WINDOW)) begin
            w_eff = WIDTH_BITS'(WINDOW);
        end else if (r_map_width > WIDTH_BITS'(MAX_WIDTH)) begin
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            w_eff = r_map_width;
        end

        if (r_chan_count == '0) begin
            chans_m1 = '0;
        end else if (r_chan_count > CHAN_BITS'(MAX_CHANNELS)) begin
            chans_m1 = CHPOS_BITS'(MAX_CHANNELS - 1);
        end else begin
            chans_m1 = CHPOS_BITS'(r_chan_count - CHAN_BITS'(1));
        end

        w_m1     = w_eff - WIDTH_BITS'(1);
        // last grid position along a side
        w_rem    = WIDTH_BITS'((w_eff - WIDTH_BITS'(WINDOW)) % STEP);
        last_pos = w_m1 - w_rem;

        row_last  = {1'b0, r_col} >= w_m1;
        map_last  = row_last && ({1'b0, r_row} >= w_m1);
        chan_last = r_chan >= chans_m1;
        mend      = ({1'b0, r_row} >= last_pos) && ({1'b0, r_col} >= last_pos);

        o_pos.emit      = on_grid(r_row) && on_grid(r_col);
        o_pos.map_end   = mend;
        o_pos.frame_end = mend && chan_last;
        o_pos.col       = r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= MAP_WIDTH_RST;
            r_chan_count <= CHAN_COUNT_RST;
            r_col        <= '0;
            r_row        <= '0;
            r_chan       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAP_WIDTH:     r_map_width  <= i_cfg_data[WIDTH_BITS-1:0];
                    CFG_CHANNEL_COUNT: r_chan_count <= i_cfg_data;
                endcase
            end
            if (i_adv) begin
                if (row_last) begin
                    r_col <= '0;
                    if (map_last) begin
                        r_row  <= '0;
                        r_chan <= chan_last ? '0 : r_chan + CHPOS_BITS'(1);
                    end else begin
                        r_row <= r_row + COL_BITS'(1);
                    end
                end else begin
                    r_col <= r_col + COL_BITS'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/max_pool_3x3_stride2.sv =====
// top level of the 3x3 stride 2 max pool over a raster pixel stream
//
//  port        dir  transfer    payload
//  i_pix       in   valid/ready pixel (signed q8.8)
//  o_pool      out  valid/ready pooled_value, map_end, frame_end
//  i_cfg_*     in   write only  i_cfg_idx selects map_width or channel_count
//
// one pixel per cycle sustained while o_pool.ready is high; the line stores
// and the window cells advance on every pixel transfer.
// after the pixel that completes its window is transferred, its result passes
// one pending stage, then the output register, before it is valid on o_pool.
// i_pix.ready drops only while both the pending stage and the output
// register hold results and o_pool.ready is low.
// synchronous reset clears counters and handshake state; line stores and
// window cells are not cleared.
`include "max_pool_3x3_stride2_macros.svh"

module max_pool_3x3_stride2 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mp_pixel_if.sink                     i_pix,
    mp_pool_if.source                    o_pool,
    input  logic                         i_cfg_we,
    input  mp_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [mp_pkg::CHAN_BITS-1:0] i_cfg_data
);
    import mp_pkg::*;

    logic      acc;
    logic      out_free;
    t_pos_info pos;
    t_column   column;
    t_value    val_chain [WINDOW];
    t_value    max_chain [WINDOW+1];

    logic      r_pend;
    logic      r_pmend;
    logic      r_pfend;
    logic      r_ov;
    t_value    r_oval;
    logic      r_omend;
    logic      r_ofend;

    assign out_free    = !r_ov || o_pool.ready;
    assign i_pix.ready = !r_pend || out_free;
    assign acc         = i_pix.valid && i_pix.ready;

    mp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_adv      (acc),
        .o_pos      (pos)
    );

    mp_line_store u_lines (
        .i_clk    (i_clk),
        .i_we     (acc),
        .i_col    (pos.col),
        .i_pixel  (i_pix.pixel),
        .o_column (column)
    );

    assign max_chain[0] = '0;

    // cell 0 holds the newest column, the last cell the oldest
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        mp_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (acc),
            .i_val   ((k == 0) ? col_max(column) : val_chain[(k == 0) ? 0 : k-1]),
            .i_max   (max_chain[k]),
            .o_val   (val_chain[k]),
            .o_max   (max_chain[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (acc) begin
                r_pend <= pos.emit;
            end else if (r_pend && out_free) begin
                r_pend <= 1'b0;
            end
            if (r_pend && out_free) begin
                r_ov <= 1'b1;
            end else if (o_pool.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // window is read from the cells when its pending result moves to the output register
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pmend <= pos.map_end;
            r_pfend <= pos.frame_end;
        end
        if (r_pend && out_free) begin
            r_oval  <= max_chain[WINDOW];
            r_omend <= r_pmend;
            r_ofend <= r_pfend;
        end
    end

    assign o_pool.valid        = r_ov;
    assign o_pool.pooled_value = r_oval;
    assign o_pool.map_end      = r_omend;
    assign o_pool.frame_end    = r_ofend;

    `MP_ASSERT_IMP(a_frame_has_map, o_pool.valid && o_pool.frame_end, o_pool.map_end)
    `MP_ASSERT_NXT(a_pend_follows_emit, acc, r_pend == $past(pos.emit))
    `MP_ASSERT_NXT(a_pend_to_out, r_pend && out_free, r_ov)
    `MP_ASSERT_IMP(a_full_blocks_in, r_pend && !out_free, !i_pix.ready)
    `MP_ASSERT_NXT(a_cells_shift, acc, val_chain[WINDOW-1] === $past(val_chain[WINDOW-2]))

endmodule
